>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on the same clock edge, quiet during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication at the next clock edge, quiet during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rte_pkg.sv
package rte_pkg;

  // Corners emitted for each rectangle
  localparam int CORNER_COUNT = 6;
  localparam int SLOT_W = 3;

  // Depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Corner order within one rectangle
  typedef enum logic [SLOT_W-1:0] {
    SLOT_BR_A = 3'd0,
    SLOT_BL   = 3'd1,
    SLOT_TL_A = 3'd2,
    SLOT_TR   = 3'd3,
    SLOT_BR_B = 3'd4,
    SLOT_TL_B = 3'd5
  } slot_t;

  // One rectangle: second vertex, held vertex and the mirror flag
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] su;
    logic signed [31:0] sv;
    logic [31:0]        pc;
    logic [23:0]        sc;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] hu;
    logic signed [31:0] hv;
    logic               mirror;
  } rect_t;

  // One emitted corner
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic [31:0]        pc;
    logic [23:0]        sc;
    slot_t              slot;
    logic               final_corner;
  } corner_t;

  // Handshake between the queue and the back part
  typedef struct packed {
    logic  valid;
    rect_t head;
  } queue_out_t;

endpackage

>>> rtl/core/rte_front.sv
module rte_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic [31:0]        primary_color,
  input  logic [23:0]        secondary_color,
  input  logic               last_of_draw,
  input  logic               q_full,
  output logic               q_push,
  output rte_pkg::rect_t     q_data
);

  logic               have_first;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_u;
  logic signed [31:0] first_v;
  logic               accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && have_first;

  // Track pairing: a first vertex is held unless it ends the draw
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
    end else if (accept) begin
      have_first <= have_first ? 1'b0 : !last_of_draw;
    end
  end

  // Hold the first vertex of a pair
  always_ff @(posedge clk) begin
    if (accept && !have_first) begin
      first_x <= pos_x;
      first_y <= pos_y;
      first_u <= tex_u;
      first_v <= tex_v;
    end
  end

  // Classify the rectangle and build the queue record
  always_comb begin
    q_data.sx     = pos_x;
    q_data.sy     = pos_y;
    q_data.sz     = pos_z;
    q_data.su     = tex_u;
    q_data.sv     = tex_v;
    q_data.pc     = primary_color;
    q_data.sc     = secondary_color;
    q_data.hx     = first_x;
    q_data.hy     = first_y;
    q_data.hu     = first_u;
    q_data.hv     = first_v;
    q_data.mirror = ((pos_x > first_x) && (pos_y < first_y)) ||
                    ((pos_x < first_x) && (pos_y > first_y));
  end

endmodule

>>> rtl/core/rte_queue.sv
module rte_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rte_pkg::rect_t        push_data,
  output logic                  full,
  input  logic                  pop,
  output rte_pkg::queue_out_t   q_out
);

  rte_pkg::rect_t                mem [rte_pkg::QUEUE_DEPTH];
  logic [rte_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rte_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rte_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign full        = (count == rte_pkg::QCNT_W'(rte_pkg::QUEUE_DEPTH));
  assign q_out       = {(count != '0), mem[rd_ptr]};
  assign do_push     = push && !full;
  assign do_pop      = pop && q_out.valid;

  // Write the incoming record
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rte_pkg::QPTR_W'(rte_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rte_pkg::QPTR_W'(rte_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/rte_back.sv
module rte_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rte_pkg::queue_out_t  q_out,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic signed [31:0]   out_u,
  output logic signed [31:0]   out_v,
  output logic [31:0]          out_primary,
  output logic [23:0]          out_secondary,
  output logic [2:0]           corner_slot,
  output logic                 final_corner
);

  rte_pkg::slot_t   slot;
  rte_pkg::slot_t   slot_next;
  rte_pkg::corner_t corner;
  rte_pkg::corner_t corner_next;
  logic             out_valid;
  logic             load;

  assign load  = q_out.valid && (!out_valid || pop);
  assign q_pop = load && (slot == rte_pkg::SLOT_TL_B);
  assign empty = !out_valid;

  // Step through the six corners
  always_comb begin
    case (slot)
      rte_pkg::SLOT_BR_A: slot_next = rte_pkg::SLOT_BL;
      rte_pkg::SLOT_BL:   slot_next = rte_pkg::SLOT_TL_A;
      rte_pkg::SLOT_TL_A: slot_next = rte_pkg::SLOT_TR;
      rte_pkg::SLOT_TR:   slot_next = rte_pkg::SLOT_BR_B;
      rte_pkg::SLOT_BR_B: slot_next = rte_pkg::SLOT_TL_B;
      default:            slot_next = rte_pkg::SLOT_BR_A;
    endcase
  end

  // Select the corner values from the head record
  always_comb begin
    corner_next.z            = q_out.head.sz;
    corner_next.pc           = q_out.head.pc;
    corner_next.sc           = q_out.head.sc;
    corner_next.slot         = slot;
    corner_next.final_corner = (slot == rte_pkg::SLOT_TL_B);
    case (slot)
      rte_pkg::SLOT_BR_A, rte_pkg::SLOT_BR_B: begin
        corner_next.x = q_out.head.sx;
        corner_next.y = q_out.head.sy;
        corner_next.u = q_out.head.su;
        corner_next.v = q_out.head.sv;
      end
      rte_pkg::SLOT_BL: begin
        corner_next.x = q_out.head.sx;
        corner_next.y = q_out.head.hy;
        corner_next.u = q_out.head.mirror ? q_out.head.hu : q_out.head.su;
        corner_next.v = q_out.head.mirror ? q_out.head.sv : q_out.head.hv;
      end
      rte_pkg::SLOT_TR: begin
        corner_next.x = q_out.head.hx;
        corner_next.y = q_out.head.sy;
        corner_next.u = q_out.head.mirror ? q_out.head.su : q_out.head.hu;
        corner_next.v = q_out.head.mirror ? q_out.head.hv : q_out.head.sv;
      end
      default: begin
        corner_next.x = q_out.head.hx;
        corner_next.y = q_out.head.hy;
        corner_next.u = q_out.head.hu;
        corner_next.v = q_out.head.hv;
      end
    endcase
  end

  // Advance slot and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= rte_pkg::SLOT_BR_A;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        slot <= slot_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the corner on the result ports
  always_ff @(posedge clk) begin
    if (load) begin
      corner <= corner_next;
    end
  end

  assign out_x         = corner.x;
  assign out_y         = corner.y;
  assign out_z         = corner.z;
  assign out_u         = corner.u;
  assign out_v         = corner.v;
  assign out_primary   = corner.pc;
  assign out_secondary = corner.sc;
  assign corner_slot   = corner.slot;
  assign final_corner  = corner.final_corner;

endmodule

>>> rtl/core/rectangle_to_triangle_expander_top.sv
// Rectangle to triangle expander.
// Input channel: transformed vertices, two per rectangle, transferred when
// push is high and full is low. The first vertex of a pair is held; the
// second one produces six corners (BR, BL, TL, TR, BR, TL) forming two
// triangles. last_of_draw restarts pairing, so an unpaired final vertex
// gives no corners.
// Result channel: a corner is on the result ports while empty is low and is
// transferred when pop is high. corner_slot gives its place 0 to 5 and
// final_corner marks the sixth.
// The second vertex of a pair is written to the queue, and each corner is
// then registered on the result ports; the rest of a rectangle's corners
// follow one per cycle while pop is held high, set by the single output
// register.
// A two-entry rectangle queue parts the input side from the corner
// sequencer, so vertices keep flowing while the receiver stalls until the
// queue fills; full then rises.
// Reset (rst, synchronous) empties the queue, drops any held vertex and
// the pending corner.
module rectangle_to_triangle_expander_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic [31:0]        primary_color,
  input  logic [23:0]        secondary_color,
  input  logic               last_of_draw,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v,
  output logic [31:0]        out_primary,
  output logic [23:0]        out_secondary,
  output logic [2:0]         corner_slot,
  output logic               final_corner
);

  logic                q_full;
  logic                q_push;
  rte_pkg::rect_t      q_data;
  logic                q_pop;
  rte_pkg::queue_out_t q_out;

  rte_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .tex_u           (tex_u),
    .tex_v           (tex_v),
    .primary_color   (primary_color),
    .secondary_color (secondary_color),
    .last_of_draw    (last_of_draw),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  rte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_out     (q_out)
  );

  rte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_out         (q_out),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_u         (out_u),
    .out_v         (out_v),
    .out_primary   (out_primary),
    .out_secondary (out_secondary),
    .corner_slot   (corner_slot),
    .final_corner  (final_corner)
  );

endmodule

>>> rtl/core/rte_checker.sv
`include "assert_macros.svh"

module rte_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_z,
  input logic [2:0]         corner_slot,
  input logic               final_corner
);

  localparam logic [2:0] LastSlot = 3'(rte_pkg::CORNER_COUNT - 1);

  // Slots stay within one rectangle
  `ASSERT_SAME(a_slot_range, !empty, corner_slot <= LastSlot, "corner slot out of range")

  // Final flag marks the last slot only
  `ASSERT_SAME(a_final_flag, !empty, final_corner == (corner_slot == LastSlot), "final flag mismatch")

  // Corners of a rectangle follow back to back
  `ASSERT_NEXT(a_slot_step, !empty && pop && !final_corner, !empty && (corner_slot == $past(corner_slot) + 3'd1), "corner sequence broken")

  // Depth is shared by all corners of a rectangle
  `ASSERT_NEXT(a_depth_shared, !empty && pop && !final_corner, out_z == $past(out_z), "depth changed within rectangle")

  // Hold the corner while the receiver stalls
  `ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(corner_slot) && $stable(out_x), "stalled corner changed")

endmodule

bind rectangle_to_triangle_expander_top rte_checker u_rte_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .out_x        (out_x),
  .out_z        (out_z),
  .corner_slot  (corner_slot),
  .final_corner (final_corner)
);

>>> tb/rte_corner_checker.sv
`timescale 1ns / 100ps

module rte_corner_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic [31:0]        primary_color,
  input  logic [23:0]        secondary_color,
  input  logic               last_of_draw,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic signed [31:0] out_u,
  input  logic signed [31:0] out_v,
  input  logic [31:0]        out_primary,
  input  logic [23:0]        out_secondary,
  input  logic [2:0]         corner_slot,
  input  logic               final_corner,
  output int                 mismatch_count,
  output int                 corners_pending
);

  // Corners still owed by the block, oldest first
  rte_pkg::corner_t   corners_due[$];
  rte_pkg::corner_t   want;
  int                 corner_index;

  // Held first vertex of the current pair
  logic               held_valid;
  logic signed [31:0] held_x;
  logic signed [31:0] held_y;
  logic signed [31:0] held_u;
  logic signed [31:0] held_v;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t: corner %0d %s: got %h, expected %h",
               $time, corner_index, what, got, exp_val);
  endtask

  // Queue one corner; z and colours always come from the second vertex
  function automatic void add_corner(input rte_pkg::slot_t slot,
                                     input logic signed [31:0] x, y, u, v);
    rte_pkg::corner_t c;
    c.x            = x;
    c.y            = y;
    c.z            = pos_z;
    c.u            = u;
    c.v            = v;
    c.pc           = primary_color;
    c.sc           = secondary_color;
    c.slot         = slot;
    c.final_corner = (slot == rte_pkg::SLOT_TL_B);
    corners_due.push_back(c);
  endfunction

  // Hold a first vertex, or expand a second one into two triangles
  function automatic void expand_vertex();
    logic               mirror;
    logic signed [31:0] bl_u, bl_v, tr_u, tr_v;
    if (!held_valid) begin
      held_x     = pos_x;
      held_y     = pos_y;
      held_u     = tex_u;
      held_v     = tex_v;
      held_valid = !last_of_draw;
      return;
    end
    mirror = (pos_x > held_x && pos_y < held_y) ||
             (pos_x < held_x && pos_y > held_y);
    bl_u = mirror ? held_u : tex_u;
    bl_v = mirror ? tex_v  : held_v;
    tr_u = mirror ? tex_u  : held_u;
    tr_v = mirror ? held_v : tex_v;
    add_corner(rte_pkg::SLOT_BR_A, pos_x,  pos_y,  tex_u,  tex_v);
    add_corner(rte_pkg::SLOT_BL,   pos_x,  held_y, bl_u,   bl_v);
    add_corner(rte_pkg::SLOT_TL_A, held_x, held_y, held_u, held_v);
    add_corner(rte_pkg::SLOT_TR,   held_x, pos_y,  tr_u,   tr_v);
    add_corner(rte_pkg::SLOT_BR_B, pos_x,  pos_y,  tex_u,  tex_v);
    add_corner(rte_pkg::SLOT_TL_B, held_x, held_y, held_u, held_v);
    held_valid = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_valid = 1'b0;
      held_x     = '0;
      held_y     = '0;
      held_u     = '0;
      held_v     = '0;
      corners_due.delete();
    end else begin
      // Compare a transferred corner with the oldest one due
      if (pop && !empty) begin
        if (corners_due.size() == 0) begin
          report_mismatch("arrived with none due", {29'b0, corner_slot}, '0);
        end else begin
          want = corners_due.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
          if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
          if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
          if (out_u !== want.u) report_mismatch("out_u", out_u, want.u);
          if (out_v !== want.v) report_mismatch("out_v", out_v, want.v);
          if (out_primary !== want.pc)
            report_mismatch("out_primary", out_primary, want.pc);
          if (out_secondary !== want.sc)
            report_mismatch("out_secondary", 32'(out_secondary), 32'(want.sc));
          if (corner_slot !== want.slot)
            report_mismatch("corner_slot", 32'(corner_slot), 32'(want.slot));
          if (final_corner !== want.final_corner)
            report_mismatch("final_corner", 32'(final_corner),
                            32'(want.final_corner));
        end
        corner_index++;
      end
      // Predict from a transferred vertex
      if (push && !full) expand_vertex();
    end
    corners_pending = corners_due.size();
  end

endmodule

>>> tb/tb_rectangle_to_triangle_expander_top.sv
`timescale 1ns / 100ps

module tb_rectangle_to_triangle_expander_top;

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic [31:0]        primary_color;
  logic [23:0]        secondary_color;
  logic               last_of_draw;
  logic               empty;
  logic               pop;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_u;
  logic signed [31:0] out_v;
  logic [31:0]        out_primary;
  logic [23:0]        out_secondary;
  logic [2:0]         corner_slot;
  logic               final_corner;

  int                 mismatch_count;
  int                 corners_pending;
  bit                 send_burst;

  rectangle_to_triangle_expander_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .tex_u           (tex_u),
    .tex_v           (tex_v),
    .primary_color   (primary_color),
    .secondary_color (secondary_color),
    .last_of_draw    (last_of_draw),
    .empty           (empty),
    .pop             (pop),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_u           (out_u),
    .out_v           (out_v),
    .out_primary     (out_primary),
    .out_secondary   (out_secondary),
    .corner_slot     (corner_slot),
    .final_corner    (final_corner)
  );

  rte_corner_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .tex_u           (tex_u),
    .tex_v           (tex_v),
    .primary_color   (primary_color),
    .secondary_color (secondary_color),
    .last_of_draw    (last_of_draw),
    .empty           (empty),
    .pop             (pop),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_u           (out_u),
    .out_v           (out_v),
    .out_primary     (out_primary),
    .out_secondary   (out_secondary),
    .corner_slot     (corner_slot),
    .final_corner    (final_corner),
    .mismatch_count  (mismatch_count),
    .corners_pending (corners_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one vertex after a random gap and hold it until its transfer
  task automatic send_vertex(input logic signed [31:0] x, y, z, u, v,
                             input logic [31:0] pc, input logic [23:0] sc,
                             input logic last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pos_x           <= x;
    pos_y           <= y;
    pos_z           <= z;
    tex_u           <= u;
    tex_v           <= v;
    primary_color   <= pc;
    secondary_color <= sc;
    last_of_draw    <= last;
    push            <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Favour small and extreme values so that equal and mirrored corners occur
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input logic last);
    send_vertex(pick_coord(), pick_coord(), $urandom, pick_coord(), pick_coord(),
                $urandom, 24'($urandom), last);
  endtask

  // Receiver: random stalls, burst stretches and one long hold-off
  initial begin
    int gap;
    int taken;
    bit pop_burst;
    pop       = 1'b0;
    taken     = 0;
    pop_burst = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (taken % 48 == 0) pop_burst = ($urandom_range(0, 3) == 0);
      gap = pop_burst ? 0 : $urandom_range(0, 11);
      // hold off long enough for the block to fill and raise full
      if (taken == 60) gap = 300;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst             = 1'b1;
    push            = 1'b0;
    pos_x           = '0;
    pos_y           = '0;
    pos_z           = '0;
    tex_u           = '0;
    tex_v           = '0;
    primary_color   = '0;
    secondary_color = '0;
    last_of_draw    = 1'b0;
    send_burst      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // plain rectangle spanning the whole range
    send_vertex(Q_MIN, Q_MIN, 0, Q_MIN, Q_MAX, 32'h0, 24'h0, 1'b0);
    send_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
    // mirrored: x grows while y falls
    send_vertex(0, 32'sh0064_0000, 0, 32'sh0001_0000, 0,
                32'h1234_5678, 24'h9A_BCDE, 1'b0);
    send_vertex(32'sh0064_0000, 0, Q_MIN, 0, 32'sh0001_0000,
                32'hA5A5_5A5A, 24'h5A_A55A, 1'b0);
    // mirrored the other way, at the extremes
    send_vertex(Q_MAX, Q_MIN, 7, 1, 2, 32'h0F0F_0F0F, 24'h0F_0F0F, 1'b0);
    send_vertex(Q_MIN, Q_MAX, -1, 3, 4, 32'hF0F0_F0F0, 24'hF0_F0F0, 1'b0);
    // same point twice: no exchange
    send_vertex(5, 5, 5, 11, 12, 32'h0000_0001, 24'h00_0001, 1'b0);
    send_vertex(5, 5, 6, 13, 14, 32'h8000_0000, 24'h80_0000, 1'b0);
    // equal x, y falling: no exchange
    send_vertex(10, 20, 0, 21, 22, 32'h1111_1111, 24'h11_1111, 1'b0);
    send_vertex(10, -20, 1, 23, 24, 32'h2222_2222, 24'h22_2222, 1'b0);
    // equal y, x falling: no exchange
    send_vertex(10, 20, 0, 31, 32, 32'h3333_3333, 24'h33_3333, 1'b0);
    send_vertex(-10, 20, 2, 33, 34, 32'h4444_4444, 24'h44_4444, 1'b0);
    // draw ends on an unpaired vertex: dropped
    send_vertex(100, 200, 300, 400, 500, 32'hDEAD_BEEF, 24'hBE_EF00, 1'b1);
    // pair closed by the end of a draw, then another unpaired last vertex
    send_vertex(-3, 3, 0, 41, 42, 32'h5555_5555, 24'h55_5555, 1'b0);
    send_vertex(3, -3, 9, 43, 44, 32'h6666_6666, 24'h66_6666, 1'b1);
    send_vertex(77, 88, 99, 45, 46, 32'h7777_7777, 24'h77_7777, 1'b1);
    // all-ones against all-zeros after the restart
    send_vertex(-1, -1, -1, -1, -1, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
    send_vertex(0, 0, 0, 0, 0, 32'h0, 24'h0, 1'b1);

    // Mostly well-formed pairs with random content, some stray vertices
    for (int n = 0; n < 180; n++) begin
      if (n % 16 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n == 90) begin
        // pause until every corner due has been transferred
        push <= 1'b0;
        do @(negedge clk); while (corners_pending != 0);
      end
      if ($urandom_range(0, 11) == 0) begin
        send_random(1'($urandom_range(0, 1)));
      end else begin
        send_random(1'b0);
        send_random($urandom_range(0, 5) == 0);
      end
    end
    push <= 1'b0;

    // Drain, then keep watching for any stray corner
    while (corners_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("** rectangle_to_triangle_expander_top: PASSED **");
    else
      $display("** rectangle_to_triangle_expander_top: FAILED **");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2_000_000;
    $display("** rectangle_to_triangle_expander_top: FAILED **");
    $finish;
  end

endmodule

>>> rectangle_to_triangle_expander_top.f
+incdir+rtl/core
rtl/core/rte_pkg.sv
rtl/core/rte_front.sv
rtl/core/rte_queue.sv
rtl/core/rte_back.sv
rtl/core/rectangle_to_triangle_expander_top.sv
rtl/core/rte_checker.sv
tb/rte_corner_checker.sv
tb/tb_rectangle_to_triangle_expander_top.sv
